// File: rtl/utf8_sentence_splitter_unit_macros.svh
// Assertion macros for the UTF-8 sentence splitter.
// Used by the top level only; bodies vanish when SYNTHESIS is defined.
`ifndef UTF8_SENTENCE_SPLITTER_UNIT_MACROS_SVH
`define UTF8_SENTENCE_SPLITTER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// ante true at an edge -> cons true at the same edge
`define U8SS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante true at an edge -> cons true at the next edge
`define U8SS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define U8SS_ASSERT_IMP(lbl, ante, cons, msg)
`define U8SS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: rtl/u8ss_pkg.sv
// Shared types and constants of the UTF-8 sentence splitter.
// No dependencies.
package u8ss_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       text_end;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       sentence_end;
        logic       blank_overflow;
        logic       last_of_item;
    } t_out;

    // what the sequencer would face next
    typedef struct packed {
        logic have_char;
        logic cnt_zero;
        logic blank_act;
        logic full;
        logic bare_act;
    } t_view;

    typedef struct packed {
        t_view now;
        t_view after_char;
        logic  out_free;
        logic  started;
        logic  cnt_one;
    } t_sts;

    typedef struct packed {
        logic accept;
        logic rd_head;
        logic emit_blank;
        logic emit_char;
        logic emit_ovf;
        logic push;
        logic emit_bare;
        logic clear_bare;
    } t_cmd;

    typedef logic [2:0] t_match;

    localparam t_match MS_NONE = 3'd0;
    localparam t_match MS_E3   = 3'd1;
    localparam t_match MS_E380 = 3'd2;
    localparam t_match MS_EF   = 3'd3;
    localparam t_match MS_EFBC = 3'd4;

    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] LEAD_E3  = 8'hE3;
    localparam logic [7:0] MID_80   = 8'h80;
    localparam logic [7:0] FIN_82   = 8'h82;
    localparam logic [7:0] LEAD_EF  = 8'hEF;
    localparam logic [7:0] MID_BC   = 8'hBC;
    localparam logic [7:0] FIN_81   = 8'h81;
    localparam logic [7:0] FIN_9F   = 8'h9F;

endpackage

// File: rtl/u8ss_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module u8ss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_q;

endmodule

// File: rtl/u8ss_ctrl.sv
// Sequencer of the sentence splitter: walks the plan of one input byte.
// Depends on u8ss_pkg.
module u8ss_ctrl
    import u8ss_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DISP = 4'd1;
    localparam logic [3:0] S_DRD  = 4'd2;
    localparam logic [3:0] S_DOUT = 4'd3;
    localparam logic [3:0] S_COUT = 4'd4;
    localparam logic [3:0] S_ORD  = 4'd5;
    localparam logic [3:0] S_OOUT = 4'd6;
    localparam logic [3:0] S_PUSH = 4'd7;
    localparam logic [3:0] S_BARE = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;

    // order: planned chars (each after queued blanks), blank, end marker
    function automatic logic [3:0] f_dispatch(input t_view v);
        logic [3:0] s;
        if (v.have_char) begin
            s = v.cnt_zero ? S_COUT : S_DRD;
        end else if (v.blank_act) begin
            s = v.full ? S_ORD : S_PUSH;
        end else if (v.bare_act) begin
            s = S_BARE;
        end else begin
            s = S_IDLE;
        end
        return s;
    endfunction

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DISP;
                end
            end
            S_DISP: begin
                n_state = f_dispatch(i_sts.now);
            end
            S_DRD: begin
                o_cmd.rd_head = 1'b1;
                n_state       = S_DOUT;
            end
            S_DOUT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_blank = 1'b1;
                    n_state          = i_sts.cnt_one ? S_COUT : S_DRD;
                end
            end
            S_COUT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_char = 1'b1;
                    n_state         = f_dispatch(i_sts.after_char);
                end
            end
            S_ORD: begin
                o_cmd.rd_head = 1'b1;
                n_state       = S_OOUT;
            end
            S_OOUT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_ovf = 1'b1;
                    n_state        = S_PUSH;
                end
            end
            S_PUSH: begin
                o_cmd.push = 1'b1;
                n_state    = i_sts.now.bare_act ? S_BARE : S_IDLE;
            end
            S_BARE: begin
                if (i_sts.started) begin
                    if (i_sts.out_free) begin
                        o_cmd.emit_bare = 1'b1;
                        n_state         = S_IDLE;
                    end
                end else begin
                    o_cmd.clear_bare = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// File: rtl/u8ss_dp.sv
// Datapath of the sentence splitter: byte plan, blank queue, output register.
// Depends on u8ss_pkg and u8ss_ram.
module u8ss_dp
    import u8ss_pkg::*;
#(
    parameter int MAX_PENDING_BLANKS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_in  i_in,
    input  t_cmd i_cmd,
    output t_sts o_sts,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);

    localparam int IDX_W = (MAX_PENDING_BLANKS > 1) ? $clog2(MAX_PENDING_BLANKS) : 1;
    localparam int CNT_W = $clog2(MAX_PENDING_BLANKS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_PENDING_BLANKS - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_PENDING_BLANKS);

    // plan of the current byte
    t_match     r_match;
    logic [7:0] r_pb [4];
    logic [3:0] r_pe;
    logic [1:0] r_pn;
    logic [1:0] r_k;
    logic       r_do_blank;
    logic       r_do_bare;
    logic [7:0] r_blank;
    logic       r_started;

    logic [IDX_W-1:0] r_head;
    logic [IDX_W-1:0] r_tail;
    logic [CNT_W-1:0] r_count;

    logic r_out_valid;
    t_out r_out;
    t_out n_out;

    // decoded plan
    logic [7:0] pb [4];
    logic [3:0] pe;
    logic [1:0] pn;
    t_match     nst;
    logic       dblank;
    logic       dbare;
    logic       is_done;
    logic       is_cont;
    logic [7:0] b;

    logic [7:0]       ram_q;
    logic [IDX_W-1:0] head_inc;
    logic [IDX_W-1:0] tail_inc;
    logic             out_free;
    logic             last_char;
    logic             load;

    always_comb begin
        b       = i_in.in_byte;
        pb      = '{default: 8'h00};
        pe      = '0;
        pn      = 2'd0;
        nst     = MS_NONE;
        dblank  = 1'b0;
        dbare   = 1'b0;
        is_done = ((r_match == MS_E380) && (b == FIN_82)) ||
                  ((r_match == MS_EFBC) && ((b == FIN_81) || (b == FIN_9F)));
        is_cont = ((r_match == MS_E3) && (b == MID_80)) ||
                  ((r_match == MS_EF) && (b == MID_BC));
        if (is_done) begin
            pb[0] = (r_match == MS_E380) ? LEAD_E3 : LEAD_EF;
            pb[1] = (r_match == MS_E380) ? MID_80 : MID_BC;
            pb[2] = b;
            pe[2] = 1'b1;
            pn    = 2'd3;
        end else if (is_cont) begin
            nst = (r_match == MS_E3) ? MS_E380 : MS_EFBC;
        end else begin
            // broken lookahead: held bytes go out as plain text
            case (r_match)
                MS_E3: begin
                    pb[0] = LEAD_E3;
                    pn    = 2'd1;
                end
                MS_E380: begin
                    pb[0] = LEAD_E3;
                    pb[1] = MID_80;
                    pn    = 2'd2;
                end
                MS_EF: begin
                    pb[0] = LEAD_EF;
                    pn    = 2'd1;
                end
                MS_EFBC: begin
                    pb[0] = LEAD_EF;
                    pb[1] = MID_BC;
                    pn    = 2'd2;
                end
                default: begin
                end
            endcase
            if (b inside {CH_DOT, CH_BANG, CH_QUEST}) begin
                pb[pn] = b;
                pe[pn] = 1'b1;
                pn     = pn + 2'd1;
            end else if (b == CH_LF) begin
                dbare = 1'b1;
            end else if (b == LEAD_E3) begin
                nst = MS_E3;
            end else if (b == LEAD_EF) begin
                nst = MS_EF;
            end else if (b inside {CH_SP, CH_TAB, CH_CR}) begin
                dblank = 1'b1;
            end else begin
                pb[pn] = b;
                pn     = pn + 2'd1;
            end
        end
        if (i_in.text_end) begin
            case (nst)
                MS_E3: begin
                    pb[pn] = LEAD_E3;
                    pn     = pn + 2'd1;
                end
                MS_EF: begin
                    pb[pn] = LEAD_EF;
                    pn     = pn + 2'd1;
                end
                // two held bytes only come from a continuation, plan is empty
                MS_E380: begin
                    pb[0] = LEAD_E3;
                    pb[1] = MID_80;
                    pn    = 2'd2;
                end
                MS_EFBC: begin
                    pb[0] = LEAD_EF;
                    pb[1] = MID_BC;
                    pn    = 2'd2;
                end
                default: begin
                end
            endcase
            nst   = MS_NONE;
            dbare = 1'b1;
        end
    end

    assign head_inc = (r_head == LAST_IDX) ? '0 : r_head + IDX_W'(1);
    assign tail_inc = (r_tail == LAST_IDX) ? '0 : r_tail + IDX_W'(1);
    assign out_free = !r_out_valid || i_out_ready;

    assign last_char = (r_k == (r_pn - 2'd1)) && !(r_do_bare && !r_pe[r_k]);

    always_comb begin
        n_out = r_out;
        load  = 1'b0;
        if (i_cmd.emit_char) begin
            n_out = '{out_byte: r_pb[r_k], byte_valid: 1'b1, sentence_end: r_pe[r_k],
                      blank_overflow: 1'b0, last_of_item: last_char};
            load  = 1'b1;
        end else if (i_cmd.emit_blank) begin
            n_out = '{out_byte: ram_q, byte_valid: 1'b1, sentence_end: 1'b0,
                      blank_overflow: 1'b0, last_of_item: 1'b0};
            load  = 1'b1;
        end else if (i_cmd.emit_ovf) begin
            n_out = '{out_byte: ram_q, byte_valid: 1'b1, sentence_end: 1'b0,
                      blank_overflow: 1'b1, last_of_item: !r_do_bare};
            load  = 1'b1;
        end else if (i_cmd.emit_bare) begin
            n_out = '{out_byte: 8'h00, byte_valid: 1'b0, sentence_end: 1'b1,
                      blank_overflow: 1'b0, last_of_item: 1'b1};
            load  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match     <= MS_NONE;
            r_pn        <= 2'd0;
            r_k         <= 2'd0;
            r_do_blank  <= 1'b0;
            r_do_bare   <= 1'b0;
            r_started   <= 1'b0;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_match    <= nst;
                r_pn       <= pn;
                r_k        <= 2'd0;
                r_do_blank <= dblank;
                r_do_bare  <= dbare;
            end
            if (i_cmd.emit_char) begin
                r_k       <= r_k + 2'd1;
                r_started <= !r_pe[r_k];
            end
            if (i_cmd.emit_blank || i_cmd.emit_ovf) begin
                r_head  <= head_inc;
                r_count <= r_count - CNT_W'(1);
            end
            if (i_cmd.push) begin
                r_tail     <= tail_inc;
                r_count    <= r_count + CNT_W'(1);
                r_do_blank <= 1'b0;
            end
            if (i_cmd.emit_bare || i_cmd.clear_bare) begin
                r_started <= 1'b0;
                r_head    <= '0;
                r_tail    <= '0;
                r_count   <= '0;
                r_do_bare <= 1'b0;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pb    <= pb;
            r_pe    <= pe;
            r_blank <= b;
        end
        if (load) begin
            r_out <= n_out;
        end
    end

    u8ss_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PENDING_BLANKS)
    ) u_blank_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.push),
        .i_wr_addr (r_tail),
        .i_wr_data (r_blank),
        .i_rd_en   (i_cmd.rd_head),
        .i_rd_addr (r_head),
        .o_rd_data (ram_q)
    );

    always_comb begin
        o_sts.now.have_char        = (r_k != r_pn);
        o_sts.now.cnt_zero         = (r_count == '0);
        o_sts.now.blank_act        = r_do_blank && r_started;
        o_sts.now.full             = (r_count == FULL_CNT);
        o_sts.now.bare_act         = r_do_bare;
        // a char empties the queue and sets started from its end flag
        o_sts.after_char.have_char = (r_k != (r_pn - 2'd1));
        o_sts.after_char.cnt_zero  = 1'b1;
        o_sts.after_char.blank_act = r_do_blank && !r_pe[r_k];
        o_sts.after_char.full      = 1'b0;
        o_sts.after_char.bare_act  = r_do_bare;
        o_sts.out_free             = out_free;
        o_sts.started              = r_started;
        o_sts.cnt_one              = (r_count == CNT_W'(1));
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// File: rtl/utf8_sentence_splitter_unit.sv
// Top level of the UTF-8 sentence splitter: sequencer plus datapath.
// Depends on u8ss_pkg, u8ss_ctrl, u8ss_dp, u8ss_ram and the macro header.
// Per accepted byte the sequencer drains queued blanks ahead of each planned char, emits
// the chars, queues a blank (an overflowed blank goes out first when the queue is full)
// and emits an end marker if the sentence closes; input is ready only in the idle state.
// Output stalls hold the sequencer. Sync active-low reset clears control; blank RAM is not.
`include "utf8_sentence_splitter_unit_macros.svh"

module utf8_sentence_splitter_unit
    import u8ss_pkg::*;
#(
    parameter int MAX_PENDING_BLANKS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    t_cmd       s_cmd;
    t_sts       s_sts;
    logic [3:0] s_loads;
    logic       s_load;

    u8ss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .o_in_ready (o_ready),
        .i_sts      (s_sts),
        .o_cmd      (s_cmd)
    );

    u8ss_dp #(
        .MAX_PENDING_BLANKS (MAX_PENDING_BLANKS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_data),
        .i_cmd       (s_cmd),
        .o_sts       (s_sts),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .o_out       (o_data)
    );

    assign s_loads = {s_cmd.emit_char, s_cmd.emit_blank, s_cmd.emit_ovf, s_cmd.emit_bare};
    assign s_load  = |s_loads;

    // a beat is loaded only into a free output register
    `U8SS_ASSERT_IMP(a_load_free, s_load, s_sts.out_free, "output beat overwritten")
    `U8SS_ASSERT_IMP(a_one_load, 1'b1, $onehot0(s_loads), "two output loads at once")
    `U8SS_ASSERT_IMP(a_push_room, s_cmd.push, !s_sts.now.full, "push into full blank queue")
    `U8SS_ASSERT_NEXT(a_ovf_push, s_cmd.emit_ovf, s_cmd.push, "overflow pop not followed by push")

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for utf8_sentence_splitter_unit: pushes text bytes through the
// valid/ready input, predicts the sentence beats in a scoreboard class, checks each output.
// Depends on u8ss_pkg and the utf8_sentence_splitter_unit RTL.
module tb_top;
    import u8ss_pkg::*;

    localparam int BLANK_DEPTH  = 16;
    localparam int RANDOM_BYTES = 215;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    t_in  i_data;
    logic o_valid;
    logic i_ready;
    t_out o_data;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int sent_count     = 0;

    class sentence_scoreboard;
        t_match     held = MS_NONE;
        bit         started;
        logic [7:0] blanks[BLANK_DEPTH];
        int         nblanks;
        t_out       awaited[$];
        int         errors;

        function void push_beat(logic [7:0] b, bit valid, bit fin, bit ovf);
            t_out r;
            r.out_byte       = b;
            r.byte_valid     = valid;
            r.sentence_end   = fin;
            r.blank_overflow = ovf;
            r.last_of_item   = 1'b0;
            awaited = {awaited, r};
        endfunction

        // a non-blank byte first releases the blanks held behind the sentence
        function void emit_text(logic [7:0] b, bit fin);
            int i;
            for (i = 0; i < nblanks; i++)
                push_beat(blanks[i], 1'b1, 1'b0, 1'b0);
            nblanks = 0;
            push_beat(b, 1'b1, fin, 1'b0);
            started = !fin;
        endfunction

        function void release_lookahead();
            case (held)
                MS_E3: emit_text(LEAD_E3, 1'b0);
                MS_E380: begin
                    emit_text(LEAD_E3, 1'b0);
                    emit_text(MID_80, 1'b0);
                end
                MS_EF: emit_text(LEAD_EF, 1'b0);
                MS_EFBC: begin
                    emit_text(LEAD_EF, 1'b0);
                    emit_text(MID_BC, 1'b0);
                end
                default: ;
            endcase
            held = MS_NONE;
        endfunction

        function void close_sentence();
            if (started)
                push_beat(8'h00, 1'b0, 1'b1, 1'b0);
            started = 1'b0;
            nblanks = 0;
        endfunction

        function void note_byte(t_in beat);
            logic [7:0] b;
            bit         taken;
            int         i;
            int         prior;
            b     = beat.in_byte;
            taken = 1'b0;
            prior = awaited.size();
            case (held)
                MS_E3: if (b == MID_80) begin
                    held  = MS_E380;
                    taken = 1'b1;
                end
                MS_E380: if (b == FIN_82) begin
                    held = MS_NONE;
                    emit_text(LEAD_E3, 1'b0);
                    emit_text(MID_80, 1'b0);
                    emit_text(b, 1'b1);
                    taken = 1'b1;
                end
                MS_EF: if (b == MID_BC) begin
                    held  = MS_EFBC;
                    taken = 1'b1;
                end
                MS_EFBC: if (b == FIN_81 || b == FIN_9F) begin
                    held = MS_NONE;
                    emit_text(LEAD_EF, 1'b0);
                    emit_text(MID_BC, 1'b0);
                    emit_text(b, 1'b1);
                    taken = 1'b1;
                end
                default: ;
            endcase
            if (!taken) begin
                // broken lookahead goes out as plain text, then b is looked at afresh
                release_lookahead();
                if (b == CH_DOT || b == CH_BANG || b == CH_QUEST)
                    emit_text(b, 1'b1);
                else if (b == CH_LF)
                    close_sentence();
                else if (b == LEAD_E3)
                    held = MS_E3;
                else if (b == LEAD_EF)
                    held = MS_EF;
                else if (b == CH_SP || b == CH_TAB || b == CH_CR) begin
                    if (started) begin
                        if (nblanks >= BLANK_DEPTH) begin
                            push_beat(blanks[0], 1'b1, 1'b0, 1'b1);
                            for (i = 0; i < BLANK_DEPTH - 1; i++)
                                blanks[i] = blanks[i + 1];
                            nblanks = BLANK_DEPTH - 1;
                        end
                        blanks[nblanks] = b;
                        nblanks++;
                    end
                end else
                    emit_text(b, 1'b0);
            end
            if (beat.text_end) begin
                release_lookahead();
                close_sentence();
            end
            if (awaited.size() > prior)
                awaited[awaited.size() - 1].last_of_item = 1'b1;
        endfunction

        task report(string what, t_out got, t_out want);
            errors++;
            $display("%0t: %s: got %h v%b e%b o%b l%b, want %h v%b e%b o%b l%b",
                     $time, what, got.out_byte, got.byte_valid, got.sentence_end,
                     got.blank_overflow, got.last_of_item, want.out_byte,
                     want.byte_valid, want.sentence_end, want.blank_overflow,
                     want.last_of_item);
        endtask

        task check_result(t_out got);
            t_out want;
            if (awaited.size() == 0) begin
                report("output beat with nothing pending", got, '0);
                return;
            end
            want = awaited.pop_front();
            if (got.out_byte !== want.out_byte)
                report("out_byte", got, want);
            if (got.byte_valid !== want.byte_valid)
                report("byte_valid", got, want);
            if (got.sentence_end !== want.sentence_end)
                report("sentence_end", got, want);
            if (got.blank_overflow !== want.blank_overflow)
                report("blank_overflow", got, want);
            if (got.last_of_item !== want.last_of_item)
                report("last_of_item", got, want);
        endtask
    endclass

    sentence_scoreboard sb = new();

    utf8_sentence_splitter_unit #(
        .MAX_PENDING_BLANKS(BLANK_DEPTH)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_data (o_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // output side: checks beats, stalls at random, and serves long hold-off requests
    initial begin
        int stall_left;
        int holds_served;
        stall_left   = 0;
        holds_served = 0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready)
                sb.check_result(o_data);
            if (holds_served != hold_requests) begin
                holds_served = hold_requests;
                stall_left   = 400;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else
                i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (b inside {CH_DOT, CH_BANG, CH_QUEST, CH_LF, CH_SP, CH_TAB, CH_CR,
                         LEAD_E3, LEAD_EF});
        return b;
    endfunction

    function automatic logic rand_end();
        return ($urandom_range(49) == 0);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic te);
        t_in beat;
        beat.in_byte  = b;
        beat.text_end = te;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= beat;
        do
            @(posedge i_clk);
        while (!o_ready);
        sb.note_byte(beat);
        sent_count++;
    endtask

    task automatic send_blanks(input int n);
        int k;
        logic [7:0] b;
        for (k = 0; k < n; k++) begin
            case ($urandom_range(2))
                0: b = CH_SP;
                1: b = CH_TAB;
                default: b = CH_CR;
            endcase
            send_byte(b, rand_end());
        end
    endtask

    task automatic send_sentence();
        int nwords;
        int w;
        int k;
        logic [7:0] lead;
        nwords = $urandom_range(1, 4);
        send_blanks($urandom_range(0, 2));
        for (w = 0; w < nwords; w++) begin
            // long gaps can overrun the blank store
            if (w > 0)
                send_blanks(($urandom_range(3) == 0) ? $urandom_range(15, 20)
                                                     : $urandom_range(1, 2));
            for (k = $urandom_range(1, 5); k > 0; k--)
                send_byte(plain_byte(), rand_end());
        end
        send_blanks($urandom_range(0, 3));
        case ($urandom_range(7))
            0: send_byte(CH_DOT, rand_end());
            1: send_byte(CH_BANG, rand_end());
            2: send_byte(CH_QUEST, rand_end());
            3: begin
                send_byte(LEAD_E3, rand_end());
                send_byte(MID_80, rand_end());
                send_byte(FIN_82, rand_end());
            end
            4: begin
                send_byte(LEAD_EF, rand_end());
                send_byte(MID_BC, rand_end());
                send_byte(FIN_81, rand_end());
            end
            5: begin
                send_byte(LEAD_EF, rand_end());
                send_byte(MID_BC, rand_end());
                send_byte(FIN_9F, rand_end());
            end
            6: send_byte(CH_LF, rand_end());
            default: begin
                lead = $urandom_range(1) ? LEAD_E3 : LEAD_EF;
                send_byte(lead, rand_end());
                if ($urandom_range(1))
                    send_byte((lead == LEAD_E3) ? MID_80 : MID_BC, rand_end());
                send_byte(plain_byte(), rand_end());
            end
        endcase
        if ($urandom_range(3) == 0)
            send_blanks($urandom_range(1, 3));
    endtask

    initial begin
        logic [8:0] directed[$];
        int         k;
        int         waited;
        bit         pressed;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_data  <= '0;
        pressed = 1'b0;
        // bit 8 is text_end
        directed = '{
            {1'b0, CH_SP}, {1'b0, 8'h00}, {1'b0, 8'hFF}, {1'b0, CH_SP},
            {1'b0, CH_TAB}, {1'b0, CH_CR}, {1'b0, 8'h7F}, {1'b0, CH_DOT},
            {1'b0, 8'h78}, {1'b0, CH_BANG}, {1'b0, CH_LF}, {1'b0, 8'h79},
            {1'b0, CH_SP}, {1'b0, CH_LF}, {1'b0, LEAD_E3}, {1'b0, MID_80},
            {1'b0, FIN_82}, {1'b0, LEAD_EF}, {1'b0, MID_BC}, {1'b0, FIN_81},
            {1'b0, LEAD_EF}, {1'b0, MID_BC}, {1'b0, FIN_9F}, {1'b0, LEAD_E3},
            {1'b0, 8'h41}, {1'b0, LEAD_E3}, {1'b0, MID_80}, {1'b0, LEAD_EF},
            {1'b0, MID_BC}, {1'b0, CH_QUEST}, {1'b0, LEAD_EF}, {1'b0, CH_LF},
            {1'b1, 8'h71}, {1'b1, LEAD_E3}, {1'b1, CH_SP}
        };
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (k = 0; k < directed.size(); k++)
            send_byte(directed[k][7:0], directed[k][8]);

        sent_count = 0;
        while (sent_count < RANDOM_BYTES) begin
            case ((sent_count / 50) % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 52;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 52;
                end
                default: begin
                    send_idle_pct  = 29;
                    recv_stall_pct = 29;
                end
            endcase
            // one long output hold-off while the input keeps pushing
            if (!pressed && sent_count >= 100) begin
                pressed = 1'b1;
                hold_requests++;
            end
            if ($urandom_range(9) < 2) begin
                for (k = $urandom_range(1, 4); k > 0; k--)
                    send_byte(8'($urandom_range(255)), rand_end());
            end else
                send_sentence();
        end
        i_valid <= 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;

        waited = 0;
        while (sb.awaited.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (20) @(posedge i_clk);
        if (sb.awaited.size() != 0)
            sb.report("beats never delivered", '0, sb.awaited[0]);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
